### hdl/gcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcc_pkg
// shared sizes and helpers for the greedy coin change block
// ----------------------------------------------------------------------------
package gcc_pkg;

	// coin slots taken part in the change, 1 to 5
	localparam int NUM_COINS   = 5;
	// width of the amount and remainder datapath, 4 to 32
	localparam int AMOUNT_BITS = 16;

	// register file always holds all five slots
	localparam int SLOT_MAX    = 5;
	localparam int SLOT_IDX_W  = 3;
	localparam int COIN_W      = 16;
	localparam int RANK_W      = 3;
	localparam int CFG_IDX_W   = 3;

	localparam int IDX_W = (NUM_COINS > 1) ? $clog2(NUM_COINS) : 1;
	localparam int BIT_W = $clog2(AMOUNT_BITS);

	// clamp a datapath value to the 16 bit result fields
	function automatic logic [COIN_W-1:0] sat_coin(input logic [AMOUNT_BITS-1:0] v);
		logic [COIN_W-1:0] r;
		if ((v >> COIN_W) != '0) begin
			r = '1;
		end else begin
			r = COIN_W'(v);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### hdl/greedy_coin_change.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// greedy_coin_change
// splits an amount greedily into coins of five programmable face values
// ----------------------------------------------------------------------------
// Each request on the input channel carries one amount. The block sorts the
// five coin values from the configuration registers into descending order
// (unused zero slots end up last), then pays out as many coins of each value
// as fit the remainder, and returns one result per slot in rank order: rank,
// value, count, plus the unpayable flag and leftover of the whole amount,
// with last_result marking the final slot. The work runs in one sequencer
// with separate compare logic for sort and division: the sort is a
// selection scan of one value per cycle, each nonzero slot takes a setup
// step plus a restoring division of one quotient bit per cycle, a zero slot
// takes only the setup step, and the results leave one per cycle while the
// sink does not stall. The block takes no new amount before the last one is
// through: in_stall is high from acceptance until the last result is loaded
// into the output register.
// Coin values are written through the cfg channel, which is always ready;
// indices above four are dropped. Writes are meant to happen only while the
// block is idle.
// ----------------------------------------------------------------------------
module greedy_coin_change
	import gcc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	// configuration write channel
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [COIN_W-1:0]     cfg_data,

	// amount request channel
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [15:0]           amount,

	// result channel
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [RANK_W-1:0]          slot_rank,
	output logic [COIN_W-1:0]          coin_value,
	output logic [COIN_W-1:0]          coin_count,
	output logic                       unpayable,
	output logic [COIN_W-1:0]          leftover,
	output logic                       last_result
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SORT,
		S_SLOT,
		S_DIV,
		S_OUT
	} state_t;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_COINS - 1);

	// coin value registers
	logic [COIN_W-1:0] coin_value_q [SLOT_MAX];

	// sequencer
	state_t            state_q;
	logic [IDX_W-1:0]  scan_idx_q;
	logic [IDX_W-1:0]  rank_q;
	logic [BIT_W-1:0]  bit_cnt_q;

	// selection sort scan
	logic [NUM_COINS-1:0] picked_q;
	logic                 have_best_q;
	logic [COIN_W-1:0]    best_val_q;
	logic [IDX_W-1:0]     best_idx_q;

	// sorted values and counts, head is the slot being worked on
	logic [COIN_W-1:0]    sorted_q [NUM_COINS];
	logic [COIN_W-1:0]    counts_q [NUM_COINS];

	// divider state
	logic [AMOUNT_BITS-1:0] rem_q;
	logic [AMOUNT_BITS-1:0] dq_q;
	logic [COIN_W-1:0]      part_q;

	// output register
	logic                   out_valid_q;
	logic [RANK_W-1:0]      slot_rank_q;
	logic [COIN_W-1:0]      res_value_q;
	logic [COIN_W-1:0]      coin_count_q;
	logic                   unpayable_q;
	logic [COIN_W-1:0]      leftover_q;
	logic                   last_result_q;

	// ---------------------------------------------------------------------
	// configuration registers
	// ---------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coin_value_q[0] <= COIN_W'(50);
			coin_value_q[1] <= COIN_W'(10);
			coin_value_q[2] <= COIN_W'(5);
			coin_value_q[3] <= COIN_W'(2);
			coin_value_q[4] <= COIN_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			// out of range indices are dropped
			if (cfg_index < CFG_IDX_W'(SLOT_MAX)) begin
				coin_value_q[SLOT_IDX_W'(cfg_index)] <= cfg_data;
			end
		end
	end

	// ---------------------------------------------------------------------
	// compare logic for sort and division
	// ---------------------------------------------------------------------
	// sort: current scan candidate against the best one so far
	logic [COIN_W-1:0] cand_val;
	logic              take;
	logic [COIN_W-1:0] sel_val;
	logic [IDX_W-1:0]  sel_idx;

	assign cand_val = coin_value_q[SLOT_IDX_W'(scan_idx_q)];
	// strict compare keeps the first of equal values
	assign take     = !picked_q[scan_idx_q] && (!have_best_q || (cand_val > best_val_q));
	assign sel_val  = take ? cand_val : best_val_q;
	assign sel_idx  = take ? scan_idx_q : best_idx_q;

	// division: one restoring step on the head value
	logic [COIN_W:0]        p_shift;
	logic                   ge;
	logic [COIN_W:0]        p_next;
	logic [AMOUNT_BITS-1:0] dq_next;

	assign p_shift = {part_q, dq_q[AMOUNT_BITS-1]};
	assign ge      = p_shift >= {1'b0, sorted_q[0]};
	assign p_next  = ge ? (p_shift - {1'b0, sorted_q[0]}) : p_shift;
	assign dq_next = {dq_q[AMOUNT_BITS-2:0], ge};

	assign in_stall = (state_q != S_IDLE);

	// ---------------------------------------------------------------------
	// sequencer and registered outputs
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			scan_idx_q  <= '0;
			rank_q      <= '0;
			bit_cnt_q   <= '0;
			picked_q    <= '0;
			have_best_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// result taken by the sink; while emitting, the output state handles it
			if (out_valid_q && !out_stall && (state_q != S_OUT)) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid && !in_stall) begin
						rem_q       <= AMOUNT_BITS'(amount);
						picked_q    <= '0;
						have_best_q <= 1'b0;
						scan_idx_q  <= '0;
						rank_q      <= '0;
						state_q     <= S_SORT;
					end
				end

				// one slot examined per cycle, largest unpicked wins
				S_SORT: begin
					if (scan_idx_q == LAST_IDX) begin
						for (int k = 0; k < NUM_COINS - 1; k++) begin
							sorted_q[k] <= sorted_q[k+1];
						end
						sorted_q[NUM_COINS-1] <= sel_val;
						picked_q[sel_idx]     <= 1'b1;
						have_best_q           <= 1'b0;
						scan_idx_q            <= '0;
						if (rank_q == LAST_IDX) begin
							rank_q  <= '0;
							state_q <= S_SLOT;
						end else begin
							rank_q <= rank_q + 1'b1;
						end
					end else begin
						best_val_q  <= sel_val;
						best_idx_q  <= sel_idx;
						have_best_q <= have_best_q | take;
						scan_idx_q  <= scan_idx_q + 1'b1;
					end
				end

				// start a slot; an unused slot pays nothing
				S_SLOT: begin
					if (sorted_q[0] == '0) begin
						for (int k = 0; k < NUM_COINS - 1; k++) begin
							sorted_q[k] <= sorted_q[k+1];
							counts_q[k] <= counts_q[k+1];
						end
						sorted_q[NUM_COINS-1] <= sorted_q[0];
						counts_q[NUM_COINS-1] <= '0;
						if (rank_q == LAST_IDX) begin
							rank_q  <= '0;
							state_q <= S_OUT;
						end else begin
							rank_q <= rank_q + 1'b1;
						end
					end else begin
						dq_q      <= rem_q;
						part_q    <= '0;
						bit_cnt_q <= BIT_W'(AMOUNT_BITS - 1);
						state_q   <= S_DIV;
					end
				end

				// one quotient bit per cycle
				S_DIV: begin
					dq_q   <= dq_next;
					part_q <= COIN_W'(p_next);
					if (bit_cnt_q == '0) begin
						rem_q <= AMOUNT_BITS'(p_next);
						for (int k = 0; k < NUM_COINS - 1; k++) begin
							sorted_q[k] <= sorted_q[k+1];
							counts_q[k] <= counts_q[k+1];
						end
						sorted_q[NUM_COINS-1] <= sorted_q[0];
						counts_q[NUM_COINS-1] <= sat_coin(dq_next);
						if (rank_q == LAST_IDX) begin
							rank_q  <= '0;
							state_q <= S_OUT;
						end else begin
							rank_q  <= rank_q + 1'b1;
							state_q <= S_SLOT;
						end
					end else begin
						bit_cnt_q <= bit_cnt_q - 1'b1;
					end
				end

				// one result per cycle into the output register while the sink does not stall
				S_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q   <= 1'b1;
						slot_rank_q   <= RANK_W'(rank_q);
						res_value_q   <= sorted_q[0];
						coin_count_q  <= counts_q[0];
						unpayable_q   <= (rem_q != '0);
						leftover_q    <= sat_coin(rem_q);
						last_result_q <= (rank_q == LAST_IDX);
						for (int k = 0; k < NUM_COINS - 1; k++) begin
							sorted_q[k] <= sorted_q[k+1];
							counts_q[k] <= counts_q[k+1];
						end
						sorted_q[NUM_COINS-1] <= sorted_q[0];
						counts_q[NUM_COINS-1] <= counts_q[0];
						if (rank_q == LAST_IDX) begin
							rank_q  <= '0;
							state_q <= S_IDLE;
						end else begin
							rank_q <= rank_q + 1'b1;
						end
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign slot_rank   = slot_rank_q;
	assign coin_value  = res_value_q;
	assign coin_count  = coin_count_q;
	assign unpayable   = unpayable_q;
	assign leftover    = leftover_q;
	assign last_result = last_result_q;

endmodule
`default_nettype wire
